>>> src/indexed_ordered_list_defines.svh
// ----------------------------------------------------------------------------
// indexed_ordered_list assertion macros
// Shared assertion forms for the list checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ILST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed_ordered_list check failed");

// Next-cycle implication, disabled while reset is high.
`define ILST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed_ordered_list check failed");

`endif

>>> src/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg
// Sizes, operation and status codes, and controller types for the list.
// ----------------------------------------------------------------------------
package ilst_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 7;
   localparam int LEN_W  = 7;
   localparam int VAL_W  = 32;
   localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [2:0] {
      OP_READ = 3'd0,
      OP_HEAD = 3'd1,
      OP_TAIL = 3'd2,
      OP_AT   = 3'd3,
      OP_DEL  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INS_LOOP,
      S_INS_WR,
      S_DEL_LOOP,
      S_DEL_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic rd_pos;
      logic rd_below;
      logic rd_above;
      logic wr_shift_ins;
      logic wr_shift_del;
      logic wr_value;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rd_hit;
      logic ins_ok;
      logic del_ok;
      logic ins_more;
      logic del_more;
   } ctrl_stat_type;

endpackage

>>> src/indexed_ordered_list.sv
// Timing: a read, a rejected operation or an unknown code passes the decode and finish states
// before its result strobe is registered; an insert or a delete also walks a read state and
// a write state for each entry moved. The next start is taken at the edge that ends the
// strobe cycle, so each operation finishes before the next is accepted. Each moved entry is
// read and then written back on the single entry RAM. Reset empties the list (length zero);
// entry contents are not cleared. The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
// indexed_ordered_list
// Ordered list of up to DEPTH signed values with read, insert and delete by position.
// ----------------------------------------------------------------------------
module indexed_ordered_list
   import ilst_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_func,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_hit,
   output logic [1:0]              rsp_status,
   output logic [LEN_W-1:0]        rsp_length
);

   // The controller owns the sequence: it captures a request transfer, lets the
   // datapath classify it, then walks the entry shift one entry at a time.
   // Insert shifts run from the tail down toward the insert point; delete shifts
   // run from the removed position up toward the tail.
   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   ilst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath holds the captured request, the list length, the entry RAM
   // and the result registers. The length only changes when the result is
   // registered, so all checks during the shift see the length before the operation.
   ilst_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_hit        (rsp_hit),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

endmodule

>>> src/ilst_ram.sv
// ----------------------------------------------------------------------------
// ilst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ilst_ram #(
   parameter int WIDTH   = 32,
   parameter int DEPTH_P = 64
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH_P)-1:0] waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       re,
   input  logic [$clog2(DEPTH_P)-1:0] raddr,
   output logic [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH_P];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/ilst_ctrl.sv
// ----------------------------------------------------------------------------
// ilst_ctrl
// Sequencer that decodes an operation and steps the entry shifts.
// ----------------------------------------------------------------------------
module ilst_ctrl
   import ilst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.ins_ok) state_in = S_INS_LOOP;
            else if (stat.del_ok) state_in = S_DEL_LOOP;
            else state_in = S_FINISH;
         end
         S_INS_LOOP: begin
            state_in = stat.ins_more ? S_INS_WR : S_FINISH;
         end
         S_INS_WR: state_in = S_INS_LOOP;
         S_DEL_LOOP: begin
            state_in = stat.del_more ? S_DEL_WR : S_FINISH;
         end
         S_DEL_WR: state_in = S_DEL_LOOP;
         S_FINISH: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: cmd.load_req = start;
         S_DECODE: cmd.rd_pos = stat.rd_hit;
         S_INS_LOOP: begin
            cmd.rd_below = stat.ins_more;
            cmd.wr_value = !stat.ins_more;
         end
         S_INS_WR: cmd.wr_shift_ins = 1'b1;
         S_DEL_LOOP: cmd.rd_above = stat.del_more;
         S_DEL_WR: cmd.wr_shift_del = 1'b1;
         S_FINISH: cmd.respond = 1'b1;
         default: cmd = '0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> src/ilst_dp.sv
// ----------------------------------------------------------------------------
// ilst_dp
// Operation registers, length, entry storage and result registers.
// ----------------------------------------------------------------------------
module ilst_dp
   import ilst_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output ctrl_stat_type           stat,
   input  logic [2:0]              req_func,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_hit,
   output logic [1:0]              rsp_status,
   output logic [LEN_W-1:0]        rsp_length
);

   func_type                func_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [VAL_W-1:0]        val_ff;
   logic [CNT_W-1:0]        cursor_ff, cursor_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_read_value_ff;
   logic                    rsp_hit_ff;
   status_type              rsp_status_ff;
   logic [LEN_W-1:0]        rsp_length_ff;

   logic [CMP_W-1:0]        pos_ext, cnt_ext, cur_ext, pos_eff;
   logic                    is_ins, ins_range, ins_full, ins_ok;
   logic                    rd_hit, rd_miss, del_ok, del_miss;
   status_type              status_code;

   logic                    ram_we, ram_re;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [VAL_W-1:0]        ram_wdata, ram_rdata;

   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);
   assign cur_ext = CMP_W'(cursor_ff);

   always_comb begin
      case (func_ff)
         OP_HEAD: pos_eff = '0;
         OP_TAIL: pos_eff = cnt_ext;
         default: pos_eff = pos_ext;
      endcase
   end

   assign is_ins    = (func_ff == OP_HEAD) || (func_ff == OP_TAIL) || (func_ff == OP_AT);
   assign ins_range = is_ins && (pos_eff > cnt_ext);
   assign ins_full  = is_ins && !ins_range && (cnt_ext == CMP_W'(DEPTH));
   assign ins_ok    = is_ins && !ins_range && !ins_full;
   assign rd_hit    = (func_ff == OP_READ) && (pos_ext < cnt_ext);
   assign rd_miss   = (func_ff == OP_READ) && !rd_hit;
   assign del_ok    = (func_ff == OP_DEL) && (pos_ext < cnt_ext);
   assign del_miss  = (func_ff == OP_DEL) && !del_ok;

   always_comb begin
      if (ins_range || rd_miss || del_miss) status_code = ST_RANGE;
      else if (ins_full) status_code = ST_FULL;
      else status_code = ST_DONE;
   end

   assign stat.rd_hit   = rd_hit;
   assign stat.ins_ok   = ins_ok;
   assign stat.del_ok   = del_ok;
   assign stat.ins_more = cur_ext > pos_eff;
   assign stat.del_more = (cur_ext + CMP_W'(1)) < cnt_ext;

   // Entry storage: one read and one write per cycle.
   assign ram_re = cmd.rd_pos || cmd.rd_below || cmd.rd_above;
   always_comb begin
      if (cmd.rd_pos) ram_raddr = ADDR_W'(pos_ext);
      else if (cmd.rd_below) ram_raddr = ADDR_W'(cursor_ff - CNT_W'(1));
      else ram_raddr = ADDR_W'(cursor_ff + CNT_W'(1));
   end

   assign ram_we    = cmd.wr_shift_ins || cmd.wr_shift_del || cmd.wr_value;
   assign ram_waddr = cmd.wr_value ? ADDR_W'(pos_eff) : ADDR_W'(cursor_ff);
   assign ram_wdata = cmd.wr_value ? val_ff : ram_rdata;

   ilst_ram #(
      .WIDTH   (VAL_W),
      .DEPTH_P (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.load_req) begin
         cursor_in = (req_func == OP_DEL) ? CNT_W'(req_position) : count_ff;
      end else if (cmd.wr_shift_ins) begin
         cursor_in = cursor_ff - CNT_W'(1);
      end else if (cmd.wr_shift_del) begin
         cursor_in = cursor_ff + CNT_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ok) count_in = count_ff + CNT_W'(1);
      else if (del_ok) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      if (cmd.load_req) begin
         func_ff <= func_type'(req_func);
         pos_ff  <= req_position;
         val_ff  <= req_value;
      end
      if (cmd.respond) begin
         rsp_read_value_ff <= rd_hit ? ram_rdata : '0;
         rsp_hit_ff        <= rd_hit;
         rsp_status_ff     <= status_code;
         rsp_length_ff     <= LEN_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.respond) count_ff <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;

endmodule

>>> src/ilst_checker.sv
// ----------------------------------------------------------------------------
// ilst_checker
// Port-level checks on the list's request and result transfers.
// ----------------------------------------------------------------------------
`include "indexed_ordered_list_defines.svh"

module ilst_checker
   import ilst_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [2:0]              req_func,
   input logic [POS_W-1:0]        req_position,
   input logic signed [VAL_W-1:0] req_value,
   input logic                    rsp_valid,
   input logic signed [VAL_W-1:0] rsp_read_value,
   input logic                    rsp_hit,
   input logic [1:0]              rsp_status,
   input logic [LEN_W-1:0]        rsp_length
);

   `ILST_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ILST_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `ILST_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `ILST_ASSERT_NOW(a_hit_done, clock, reset, rsp_valid && rsp_hit, rsp_status == ST_DONE)
   `ILST_ASSERT_NOW(a_full_len, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_length == LEN_W'(DEPTH))

endmodule

bind indexed_ordered_list ilst_checker u_ilst_checker (.*);

>>> tb/sv/indexed_ordered_list_tb.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list_tb
// Self-checking bench for the indexed ordered list: it drives read, insert and
// delete commands through the start/busy handshake, keeps a shadow copy of the
// list to predict each response, and compares every response field by field.
// ----------------------------------------------------------------------------
module indexed_ordered_list_tb
   import ilst_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Function codes 5 to 7 are not assigned; the block must treat them as no-ops.
   localparam logic [2:0] OP_RSVD_LO = 3'd5;
   localparam logic [2:0] OP_RSVD_HI = 3'd7;

   // Extreme data values; between them every bit of the value field is toggled.
   localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_ZERO = 32'sh0000_0000;
   localparam logic signed [VAL_W-1:0] VAL_ONES = 32'shFFFF_FFFF;

   // One response as the block presents it.
   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic                    hit;
      logic [1:0]              status;
      logic [LEN_W-1:0]        length;
   } list_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [2:0]              req_func = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic                    rsp_hit;
   logic [1:0]              rsp_status;
   logic [LEN_W-1:0]        rsp_length;

   // Shadow of the list contents, head first, and the responses still owed by
   // the block in the order their commands were accepted.
   logic signed [VAL_W-1:0] list_shadow[$];
   list_result_type         pending_results[$];
   int                      err_count = 0;
   bit                      idle_enable = 1'b1;

   indexed_ordered_list uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_hit        (rsp_hit),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one command to the shadow list and returns the response the block
   // owes for it. The position check of an insert comes ahead of the full check,
   // so a position past the length reports out of range even on a full list.
   function automatic list_result_type apply_list_op(input logic [2:0]              func,
                                                     input logic [POS_W-1:0]        pos,
                                                     input logic signed [VAL_W-1:0] value);
      list_result_type res;
      int              len;
      int              slot;
      res  = '0;
      len  = list_shadow.size();
      slot = pos;
      case (func)
         OP_READ: begin
            if (slot < len) begin
               res.read_value = list_shadow[slot];
               res.hit        = 1'b1;
            end else begin
               res.status = ST_RANGE;
            end
         end
         OP_HEAD, OP_TAIL, OP_AT: begin
            if (func == OP_HEAD) begin
               slot = 0;
            end else if (func == OP_TAIL) begin
               slot = len;
            end
            if (slot > len) begin
               res.status = ST_RANGE;
            end else if (len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               list_shadow.insert(slot, value);
            end
         end
         OP_DEL: begin
            if (slot >= len) begin
               res.status = ST_RANGE;
            end else begin
               list_shadow.delete(slot);
            end
         end
         default: begin
            // Unassigned codes leave the list alone and report done.
         end
      endcase
      res.length = LEN_W'(list_shadow.size());
      return res;
   endfunction

   // Mostly random words, with the extremes mixed in now and then.
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return VAL_ZERO;
         3:       return VAL_ONES;
         default: return $urandom;
      endcase
   endfunction

   // Sends one command. The bench may first drop start for a random idle gap; it
   // then holds start high with the command until a rising edge sees busy low,
   // which is the edge of the transfer. Busy is read right after the edge, so
   // it still holds the value the block presented at that edge. The response
   // is predicted at the transfer, since that is when the block takes it.
   task automatic send_op(input logic [2:0] func, input int pos,
                          input logic signed [VAL_W-1:0] value);
      if (idle_enable && $urandom_range(0, 99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start        <= 1'b1;
      req_func     <= func;
      req_position <= pos[POS_W-1:0];
      req_value    <= value;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_list_op(func, pos[POS_W-1:0], value));
   endtask

   // Every strobe must match the oldest prediction. The block cannot be held
   // off, so each strobe is a completed transfer and is checked at its edge.
   always @(posedge clock) begin : response_check
      list_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with nothing outstanding, length %0d",
                     $realtime, rsp_length);
            err_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $display("%0t: read_value expected %0d, got %0d",
                        $realtime, want.read_value, rsp_read_value);
               err_count++;
            end
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0b, got %0b", $realtime, want.hit, rsp_hit);
               err_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $realtime, want.status, rsp_status);
               err_count++;
            end
            if (rsp_length !== want.length) begin
               $display("%0t: length expected %0d, got %0d",
                        $realtime, want.length, rsp_length);
               err_count++;
            end
         end
      end
   end

   // Commands on an empty list: read misses at positions zero and DEPTH,
   // a delete out of range, inserts past the length, and the
   // unassigned function codes.
   task automatic test_empty_list();
      int code;
      send_op(OP_READ, 0, VAL_ZERO);
      send_op(OP_READ, DEPTH, VAL_ZERO);
      send_op(OP_DEL, 0, VAL_ZERO);
      send_op(OP_AT, 1, VAL_MAX);
      send_op(OP_AT, DEPTH, VAL_MIN);
      for (code = OP_RSVD_LO; code <= OP_RSVD_HI; code++) begin
         send_op(code[2:0], $urandom_range(0, DEPTH), pick_value());
      end
   endtask

   // Each insert form and delete on a short list, with extreme values, reads
   // across the whole list and one past it, and an insert past the length.
   task automatic test_basic_ops();
      int idx;
      send_op(OP_HEAD, 0, VAL_MAX);
      send_op(OP_TAIL, 0, VAL_MIN);
      send_op(OP_AT, 1, VAL_ONES);
      send_op(OP_AT, 0, VAL_ZERO);
      send_op(OP_AT, 4, 32'sh5555_AAAA);
      send_op(OP_AT, 6, VAL_MAX);
      for (idx = 0; idx <= 5; idx++) begin
         send_op(OP_READ, idx, VAL_ZERO);
      end
      send_op(OP_DEL, 2, VAL_ZERO);
      send_op(OP_DEL, 3, VAL_ZERO);
      send_op(OP_DEL, 0, VAL_ZERO);
      send_op(OP_DEL, 2, VAL_ZERO);
      send_op(OP_READ, 0, VAL_ZERO);
      send_op(OP_READ, 1, VAL_ZERO);
   endtask

   // Fills the list with random inserts, exercises refused inserts on a full
   // list and the positions at its end, then drains it with random deletes.
   task automatic test_full_list();
      int len;
      while (list_shadow.size() < DEPTH) begin
         len = list_shadow.size();
         case ($urandom_range(0, 2))
            0:       send_op(OP_HEAD, 0, pick_value());
            1:       send_op(OP_TAIL, 0, pick_value());
            default: send_op(OP_AT, $urandom_range(0, len), pick_value());
         endcase
      end
      send_op(OP_HEAD, 0, pick_value());
      send_op(OP_TAIL, 0, pick_value());
      send_op(OP_AT, DEPTH, pick_value());
      send_op(OP_AT, $urandom_range(0, DEPTH - 1), pick_value());
      send_op(OP_READ, DEPTH - 1, VAL_ZERO);
      send_op(OP_READ, DEPTH, VAL_ZERO);
      send_op(OP_DEL, DEPTH, VAL_ZERO);
      send_op(OP_DEL, DEPTH - 1, VAL_ZERO);
      send_op(OP_AT, DEPTH - 1, pick_value());
      send_op(OP_READ, DEPTH - 1, VAL_ZERO);
      while (list_shadow.size() > 0) begin
         len = list_shadow.size();
         if ($urandom_range(0, 3) == 0) begin
            send_op(OP_READ, $urandom_range(0, len - 1), VAL_ZERO);
         end
         send_op(OP_DEL, $urandom_range(0, len - 1), VAL_ZERO);
      end
   endtask

   // Random commands. The mix drifts between a growing and a shrinking phase
   // so the length sweeps the whole range, full list included. Most positions
   // are legal for the current length; a few commands are noise with any
   // position or an unassigned code. One stretch runs with no idle cycles.
   task automatic test_random_ops(input int n_items);
      int  i;
      int  len;
      int  pick;
      bit  growing;
      growing = 1'b1;
      for (i = 0; i < n_items; i++) begin
         idle_enable = !(i >= 300 && i < 500);
         len = list_shadow.size();
         if ((len == DEPTH && $urandom_range(0, 7) == 0) ||
             (len == 0 && $urandom_range(0, 3) == 0) || $urandom_range(0, 39) == 0) begin
            growing = !growing;
         end
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_op(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), $urandom_range(0, DEPTH),
                    pick_value());
         end else if (pick < 8) begin
            send_op(3'($urandom_range(OP_READ, OP_DEL)), $urandom_range(0, DEPTH),
                    pick_value());
         end else if (pick < 33) begin
            send_op(OP_READ, (len == 0) ? 0 : $urandom_range(0, len - 1), VAL_ZERO);
         end else if (pick < (growing ? 83 : 53)) begin
            case ($urandom_range(0, 2))
               0:       send_op(OP_HEAD, $urandom_range(0, DEPTH), pick_value());
               1:       send_op(OP_TAIL, $urandom_range(0, DEPTH), pick_value());
               default: send_op(OP_AT, $urandom_range(0, len), pick_value());
            endcase
         end else begin
            send_op(OP_DEL, (len == 0) ? 0 : $urandom_range(0, len - 1), pick_value());
         end
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_ops();
      test_full_list();
      test_random_ops(620);
      start <= 1'b0;
      // Every command owes exactly one response; once they are all in, a
      // short wait shows that no stray strobe follows.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("indexed_ordered_list verification clean");
      end else begin
         $display("indexed_ordered_list verification failed");
      end
      $finish;
   end

   // The slowest correct run of about eight hundred commands, idle gaps included,
   // stays well under this.
   initial begin
      #20ms;
      $display("indexed_ordered_list verification failed");
      $finish;
   end

endmodule
